// ----- hdl/phb_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helpers of the position heatmap binner
package phb_pkg;

	localparam int GRID_SIZE    = 100;
	localparam int COUNT_BITS   = 16;
	localparam int PLAYERS      = 4;
	localparam int CELLS        = GRID_SIZE * GRID_SIZE;
	localparam int PLAYER_CELLS = PLAYERS * CELLS;
	localparam int BIN_W        = $clog2(GRID_SIZE);
	localparam int CADDR_W      = $clog2(CELLS);
	localparam int PADDR_W      = $clog2(PLAYER_CELLS);
	localparam int PLAYER_W     = $clog2(PLAYERS);

	localparam int COORD_OFFSET = 2000;
	localparam int BIN_SPAN     = 40;
	localparam int GRID_SPAN    = GRID_SIZE * BIN_SPAN;
	localparam int COORD_W      = $clog2(GRID_SPAN);
	// bin = (v >> 3) / 5, the divide by five done as a multiply by 2^18/5 rounded up
	localparam int DIV5_SHIFT   = 18;
	localparam int DIV5_MUL     = 52429;
	localparam int DIV5_IN_W    = COORD_W - 3;

	localparam int DENSITY_SCALE = 2000;
	localparam int SCALE_W       = 11;
	localparam int NORM_W        = 18;
	localparam int PROD_W        = COUNT_BITS + SCALE_W;
	localparam int CMP_W         = (PROD_W > NORM_W + 2) ? PROD_W : NORM_W + 2;

	localparam int CFG_DATA_W = 18;
	localparam int MAP_SEL_W  = 3;

	localparam logic OP_RECORD  = 1'b0;
	localparam logic OP_READOUT = 1'b1;

	localparam logic [MAP_SEL_W-1:0] MAP_ALL = 3'd4;

	typedef enum logic [1:0] {
		CFG_WINDOW_FIRST = 2'd0,
		CFG_WINDOW_LAST  = 2'd1,
		CFG_PLAYER_NORM  = 2'd2,
		CFG_ALL_NORM     = 2'd3
	} cfg_index_t;

	localparam logic [15:0]       WINDOW_FIRST_RST = 16'd1;
	localparam logic [15:0]       WINDOW_LAST_RST  = 16'd15000;
	localparam logic [15:0]       PLAYER_NORM_RST  = 16'd14999;
	localparam logic [NORM_W-1:0] ALL_NORM_RST     = 18'd59996;

	localparam logic [2:0] CLASS_EMPTY = 3'd0;
	localparam logic [2:0] CLASS_LOW   = 3'd1;
	localparam logic [2:0] CLASS_MID   = 3'd2;
	localparam logic [2:0] CLASS_HIGH  = 3'd3;
	localparam logic [2:0] CLASS_DENSE = 3'd4;
	localparam logic [2:0] CLASS_PEAK  = 3'd5;

	typedef struct packed {
		logic                  opcode;
		logic [1:0]            player;
		logic [15:0]           stamp;
		logic signed [15:0]    raw_x;
		logic signed [15:0]    raw_y;
		logic [MAP_SEL_W-1:0]  map_select;
		logic [6:0]            bin_col;
		logic [6:0]            bin_row;
	} req_t;

	typedef struct packed {
		logic        counted;
		logic        off_grid;
		logic [15:0] bin_count;
		logic [2:0]  colour_class;
	} rsp_t;

	// offset coordinate, 17 bits signed so the full input range fits
	function automatic logic signed [16:0] shift_coord(input logic signed [15:0] raw);
		return 17'(signed'({raw[15], raw})) + 17'(COORD_OFFSET);
	endfunction

	function automatic logic on_grid(input logic signed [16:0] v);
		return (v >= 17'sd0) && (v < 17'(GRID_SPAN));
	endfunction

	// valid only for an on-grid coordinate
	function automatic logic [BIN_W-1:0] bin_of(input logic signed [16:0] v);
		logic [DIV5_IN_W-1:0]            eighth;
		logic [DIV5_IN_W+DIV5_SHIFT-1:0] prod;
		eighth = v[COORD_W-1:3];
		prod   = (DIV5_IN_W+DIV5_SHIFT)'(eighth) * (DIV5_IN_W+DIV5_SHIFT)'(DIV5_MUL);
		return prod[DIV5_SHIFT +: BIN_W];
	endfunction

endpackage

// ----- hdl/phb_ram.sv -----
`timescale 1ns / 1ps
// generic single-port ram, registered read, read before write
module phb_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- hdl/phb_classify.sv -----
`timescale 1ns / 1ps
// density colour class from a scaled count and the map's normaliser
module phb_classify (
	input  logic [phb_pkg::COUNT_BITS-1:0] count,
	input  logic [phb_pkg::PROD_W-1:0]     prod,
	input  logic [phb_pkg::NORM_W-1:0]     norm,
	output logic [2:0]                     colour_class
);

	import phb_pkg::*;

	logic [CMP_W-1:0] c;
	logic [CMP_W-1:0] n1;
	logic [CMP_W-1:0] n2;
	logic [CMP_W-1:0] n3;
	logic [CMP_W-1:0] n4;

	assign c  = CMP_W'(prod);
	assign n1 = CMP_W'(norm);
	assign n2 = CMP_W'({norm, 1'b0});
	assign n3 = CMP_W'(n1 + n2);
	assign n4 = CMP_W'({norm, 2'b00});

	always_comb begin
		if (count == '0) begin
			colour_class = CLASS_EMPTY;
		end else if (norm == '0) begin
			colour_class = CLASS_PEAK;
		end else if (c <= n1) begin
			colour_class = CLASS_LOW;
		end else if (c < n2) begin
			colour_class = CLASS_MID;
		end else if (c < n3) begin
			colour_class = CLASS_HIGH;
		end else if (c < n4) begin
			colour_class = CLASS_DENSE;
		end else begin
			colour_class = CLASS_PEAK;
		end
	end

endmodule

// ----- hdl/position_heatmap_binner.sv -----
`timescale 1ns / 1ps
// position heatmap binner: per-player and combined 2d position histograms
//
// Requests arrive on req_valid/req_ready with a req_t payload. A record request
// (opcode 0) bins raw x and y into a 100 x 100 grid and, if it lands on the grid
// and its stamp lies in the configured window, adds one (saturating) to that
// player's map and to the combined map. A readout request (opcode 1) returns one
// bin's count and colour class from the chosen map and, if the selection is
// valid, clears that bin. Every request gives one result on rsp_valid/rsp_ready.
// A request runs through the read-modify-write sequence on the bin rams (bin,
// address, read, modify, result, then back in idle) before the next one is
// accepted. The result is registered in the result step, after the write-back.
// The output register holds a result while the receiver stalls; the next
// request is already taken and is held in its result step until the register
// frees.
// After reset both maps are cleared by a pass over the 40000 player-map entries
// (one per cycle, the 10000 combined-map entries alongside the first 10000),
// during which req_ready stays low. Configuration writes (cfg_we, cfg_index,
// cfg_data) reset to window 1..15000, normalisers 14999 and 59996.
module position_heatmap_binner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  phb_pkg::cfg_index_t           cfg_index,
	input  logic [phb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  phb_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output phb_pkg::rsp_t                 rsp
);

	import phb_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_BIN   = 7'b0000100,
		ST_ADDR  = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_MOD   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0]       window_first_q;
	logic [15:0]       window_last_q;
	logic [15:0]       player_norm_q;
	logic [NORM_W-1:0] all_norm_q;

	logic [PADDR_W-1:0] clr_q;

	req_t               req_q;
	logic [BIN_W-1:0]   bx_q;
	logic [BIN_W-1:0]   by_q;
	logic [PLAYER_W-1:0] map_q;
	logic               off_q;
	logic               hit_q;
	logic               rd_ok_q;
	logic               is_all_q;
	logic [CADDR_W-1:0] caddr_q;
	logic [PADDR_W-1:0] paddr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PROD_W-1:0]  prod_q;
	logic [NORM_W-1:0]  norm_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic signed [16:0] vx;
	logic signed [16:0] vy;
	logic               grid_ok;
	logic               in_window;
	logic               sel_ok;

	logic                  p_we;
	logic [PADDR_W-1:0]    p_addr;
	logic [COUNT_BITS-1:0] p_wdata;
	logic [COUNT_BITS-1:0] p_rdata;
	logic                  c_we;
	logic [CADDR_W-1:0]    c_addr;
	logic [COUNT_BITS-1:0] c_wdata;
	logic [COUNT_BITS-1:0] c_rdata;
	logic [COUNT_BITS-1:0] sel_count;
	logic [2:0]            colour;
	logic                  out_free;

	assign vx        = shift_coord(req_q.raw_x);
	assign vy        = shift_coord(req_q.raw_y);
	assign grid_ok   = on_grid(vx) && on_grid(vy);
	assign in_window = (req_q.stamp >= window_first_q) && (req_q.stamp <= window_last_q);
	assign sel_ok    = (req_q.map_select <= MAP_ALL)
		&& (int'(req_q.bin_col) < GRID_SIZE) && (int'(req_q.bin_row) < GRID_SIZE);

	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sel_count = is_all_q ? c_rdata : p_rdata;

	// ram port muxing: clearing pass, then read in ST_READ and write back in ST_MOD
	always_comb begin
		p_we    = 1'b0;
		c_we    = 1'b0;
		p_addr  = paddr_q;
		c_addr  = caddr_q;
		p_wdata = '0;
		c_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				p_we   = 1'b1;
				c_we   = (int'(clr_q) < CELLS);
				p_addr = clr_q;
				c_addr = CADDR_W'(clr_q);
			end
			ST_MOD: begin
				if (hit_q) begin
					p_we    = 1'b1;
					c_we    = 1'b1;
					p_wdata = (p_rdata == '1) ? p_rdata : p_rdata + 1'b1;
					c_wdata = (c_rdata == '1) ? c_rdata : c_rdata + 1'b1;
				end else if (rd_ok_q) begin
					p_we = !is_all_q;
					c_we = is_all_q;
				end
			end
			default: begin
			end
		endcase
	end

	phb_ram #(
		.DEPTH(PLAYER_CELLS),
		.WIDTH(COUNT_BITS)
	) u_player_ram (
		.clk  (clk),
		.we   (p_we),
		.addr (p_addr),
		.wdata(p_wdata),
		.rdata(p_rdata)
	);

	phb_ram #(
		.DEPTH(CELLS),
		.WIDTH(COUNT_BITS)
	) u_combined_ram (
		.clk  (clk),
		.we   (c_we),
		.addr (c_addr),
		.wdata(c_wdata),
		.rdata(c_rdata)
	);

	phb_classify u_classify (
		.count       (count_q),
		.prod        (prod_q),
		.norm        (norm_q),
		.colour_class(colour)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_first_q <= WINDOW_FIRST_RST;
			window_last_q  <= WINDOW_LAST_RST;
			player_norm_q  <= PLAYER_NORM_RST;
			all_norm_q     <= ALL_NORM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_FIRST: window_first_q <= cfg_data[15:0];
				CFG_WINDOW_LAST:  window_last_q  <= cfg_data[15:0];
				CFG_PLAYER_NORM:  player_norm_q  <= cfg_data[15:0];
				CFG_ALL_NORM:     all_norm_q     <= cfg_data[NORM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == PLAYER_CELLS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_BIN;
					end
				end
				ST_BIN:  state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_MOD;
				ST_MOD:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req;
			end
			ST_BIN: begin
				if (req_q.opcode == OP_RECORD) begin
					bx_q     <= bin_of(vx);
					by_q     <= bin_of(vy);
					map_q    <= req_q.player;
					off_q    <= !grid_ok;
					hit_q    <= grid_ok && in_window;
					rd_ok_q  <= 1'b0;
					is_all_q <= 1'b0;
				end else begin
					bx_q     <= BIN_W'(req_q.bin_col);
					by_q     <= BIN_W'(req_q.bin_row);
					map_q    <= req_q.map_select[PLAYER_W-1:0];
					off_q    <= 1'b0;
					hit_q    <= 1'b0;
					rd_ok_q  <= sel_ok;
					is_all_q <= (req_q.map_select == MAP_ALL);
				end
			end
			ST_ADDR: begin
				caddr_q <= CADDR_W'(CADDR_W'(bx_q) * CADDR_W'(GRID_SIZE) + CADDR_W'(by_q));
				paddr_q <= PADDR_W'(PADDR_W'(map_q) * PADDR_W'(CELLS)
					+ PADDR_W'(bx_q) * PADDR_W'(GRID_SIZE) + PADDR_W'(by_q));
			end
			ST_MOD: begin
				count_q <= rd_ok_q ? sel_count : '0;
				prod_q  <= PROD_W'(sel_count) * PROD_W'(DENSITY_SCALE);
				norm_q  <= is_all_q ? all_norm_q : NORM_W'(player_norm_q);
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q.counted      <= hit_q;
					rsp_q.off_grid     <= off_q;
					rsp_q.bin_count    <= 16'(count_q);
					rsp_q.colour_class <= colour;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
